/* src/box_stk_pkg.sv */
package box_stk_pkg;

   // Width and ceiling of the reported stack height.
   localparam int HEIGHT_W = 24;
   localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = {HEIGHT_W{1'b1}};

   // Every loaded box yields one orientation per dimension.
   localparam int ORIENTS_PER_BOX = 3;

endpackage

/* src/box_stacking_max_height.sv */
// Channel | Dir | Handshake            | Word
// req     | in  | req_valid/req_stall  | req_side_a/b/c, req_no_box, req_last_box
// rsp     | out | rsp_valid/rsp_stall  | rsp_best_height
//
// A box word takes the accept plus one store write per orientation. A word without a
// box, or one the full store drops, takes only the accept. A closing word adds the
// ranking pass, the stacking pass and the emit, plus any wait on rsp_stall.
// Reset is synchronous and clears the sequencer, the orientation count and rsp_valid.
// req_stall is high while a word is in work; a finished result waits in the output
// register on rsp_stall while the next word is accepted.
module box_stacking_max_height #(
   parameter int MAX_TYPES = 64,
   parameter int SIDE_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [SIDE_BITS-1:0]               req_side_a,
   input  logic [SIDE_BITS-1:0]               req_side_b,
   input  logic [SIDE_BITS-1:0]               req_side_c,
   input  logic                               req_no_box,
   input  logic                               req_last_box,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [box_stk_pkg::HEIGHT_W-1:0]   rsp_best_height
);

   localparam int ORIENTS = box_stk_pkg::ORIENTS_PER_BOX * MAX_TYPES;
   localparam int CNT_W   = $clog2(ORIENTS + 1);
   localparam int IDX_W   = $clog2(ORIENTS);
   localparam int ENT_W   = 3 * SIDE_BITS;
   localparam int KEY_W   = SIDE_BITS + 1;
   localparam int HT_W    = box_stk_pkg::HEIGHT_W;
   localparam int SUM_W   = ((SIDE_BITS > HT_W) ? SIDE_BITS : HT_W) + 1;

   // The sequencer. Loading writes the three orientations, ranking places each
   // orientation by the sum of its base sides (a strict nesting always lowers that
   // sum, so the rank order is a valid stacking order), and the stacking pass runs
   // the longest-chain recurrence over the ranked list.
   typedef enum logic [3:0] {
      S_IDLE, S_LOAD,
      S_RK_J, S_RK_JL, S_RK_I, S_RK_C, S_RK_PUT,
      S_DP_J, S_DP_JL, S_DP_I, S_DP_C, S_DP_PUT,
      S_EMIT
   } state_type;

   state_type            state_ff, state_in;
   logic [1:0]           phase_ff, phase_in;
   logic [SIDE_BITS-1:0] a_ff, a_in, b_ff, b_in, c_ff, c_in;
   logic                 last_ff, last_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     j_ff, j_in, i_ff, i_in, rank_ff, rank_in;
   logic [ENT_W-1:0]     cur_ff, cur_in;
   logic [HT_W-1:0]      top_ff, top_in, best_ff, best_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [HT_W-1:0]      rsp_height_ff, rsp_height_in;

   // Stores: the loaded orientations, the ranked copy and the chain heights.
   logic [ENT_W-1:0] orient_mem [ORIENTS];
   logic [ENT_W-1:0] sorted_mem [ORIENTS];
   logic [HT_W-1:0]  height_mem [ORIENTS];
   logic [ENT_W-1:0] orient_rd_ff, sorted_rd_ff;
   logic [HT_W-1:0]  height_rd_ff;

   logic [IDX_W-1:0] orient_raddr, sorted_raddr;
   logic             orient_we, sorted_we, height_we;
   logic [ENT_W-1:0] orient_wdata;

   logic                 req_take, put_fits;
   logic [CNT_W:0]       count_plus;
   logic [SIDE_BITS-1:0] ld_h, ld_s, ld_t, ld_w, ld_d;
   logic [KEY_W-1:0]     key_i, key_cur;
   logic                 first_i;
   logic [SUM_W-1:0]     cand_sum, cur_h_ext;
   logic [HT_W-1:0]      cand_sat;

   assign req_stall       = (state_ff != S_IDLE);
   assign req_take        = req_valid && !req_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_best_height = rsp_height_ff;

   assign count_plus = {1'b0, count_ff} + (CNT_W+1)'(box_stk_pkg::ORIENTS_PER_BOX);
   assign put_fits   = (count_plus <= (CNT_W+1)'(ORIENTS));

   // Orientation for the current load phase: one dimension is the height and the
   // other two form the base, narrow side first.
   always_comb begin
      case (phase_ff)
         2'd0: begin
            ld_h = a_ff; ld_s = b_ff; ld_t = c_ff;
         end
         2'd1: begin
            ld_h = b_ff; ld_s = c_ff; ld_t = a_ff;
         end
         default: begin
            ld_h = c_ff; ld_s = a_ff; ld_t = b_ff;
         end
      endcase
      ld_w = (ld_s < ld_t) ? ld_s : ld_t;
      ld_d = (ld_s < ld_t) ? ld_t : ld_s;
   end

   assign orient_wdata = {ld_w, ld_d, ld_h};

   // Rank comparison: larger base sum goes first, equal sums keep load order.
   assign key_i   = KEY_W'(orient_rd_ff[ENT_W-1 -: SIDE_BITS])
                  + KEY_W'(orient_rd_ff[2*SIDE_BITS-1 -: SIDE_BITS]);
   assign key_cur = KEY_W'(cur_ff[ENT_W-1 -: SIDE_BITS])
                  + KEY_W'(cur_ff[2*SIDE_BITS-1 -: SIDE_BITS]);
   assign first_i = (key_i > key_cur) || ((key_i == key_cur) && (i_ff < j_ff));

   // Candidate chain height, held at the 24-bit ceiling.
   assign cur_h_ext = SUM_W'(cur_ff[SIDE_BITS-1:0]);
   assign cand_sum  = SUM_W'(height_rd_ff) + cur_h_ext;
   assign cand_sat  = (cand_sum > SUM_W'(box_stk_pkg::HEIGHT_MAX)) ?
                      box_stk_pkg::HEIGHT_MAX : cand_sum[HT_W-1:0];

   assign orient_raddr = (state_ff == S_RK_J) ? j_ff[IDX_W-1:0] : i_ff[IDX_W-1:0];
   assign sorted_raddr = (state_ff == S_DP_J) ? j_ff[IDX_W-1:0] : i_ff[IDX_W-1:0];
   assign orient_we    = (state_ff == S_LOAD);
   assign sorted_we    = (state_ff == S_RK_PUT);
   assign height_we    = (state_ff == S_DP_PUT);

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      c_in          = c_ff;
      last_in       = last_ff;
      count_in      = count_ff;
      j_in          = j_ff;
      i_in          = i_ff;
      rank_in       = rank_ff;
      cur_in        = cur_ff;
      top_in        = top_ff;
      best_in       = best_ff;
      rsp_height_in = rsp_height_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               a_in     = req_side_a;
               b_in     = req_side_b;
               c_in     = req_side_c;
               last_in  = req_last_box;
               phase_in = 2'd0;
               j_in     = '0;
               if (!req_no_box && put_fits) begin
                  state_in = S_LOAD;
               end else if (req_last_box) begin
                  state_in = S_RK_J;
               end
            end
         end
         S_LOAD: begin
            count_in = count_ff + CNT_W'(1);
            phase_in = phase_ff + 2'd1;
            if (phase_ff == 2'd2) begin
               state_in = last_ff ? S_RK_J : S_IDLE;
            end
         end
         S_RK_J: begin
            if (j_ff == count_ff) begin
               j_in     = '0;
               state_in = S_DP_J;
            end else begin
               state_in = S_RK_JL;
            end
         end
         S_RK_JL: begin
            cur_in   = orient_rd_ff;
            rank_in  = '0;
            i_in     = '0;
            state_in = S_RK_I;
         end
         S_RK_I: begin
            state_in = (i_ff == count_ff) ? S_RK_PUT : S_RK_C;
         end
         S_RK_C: begin
            if (first_i) begin
               rank_in = rank_ff + CNT_W'(1);
            end
            i_in     = i_ff + CNT_W'(1);
            state_in = S_RK_I;
         end
         S_RK_PUT: begin
            j_in     = j_ff + CNT_W'(1);
            state_in = S_RK_J;
         end
         S_DP_J: begin
            state_in = (j_ff == count_ff) ? S_EMIT : S_DP_JL;
         end
         S_DP_JL: begin
            cur_in   = sorted_rd_ff;
            top_in   = (SUM_W'(sorted_rd_ff[SIDE_BITS-1:0]) >
                        SUM_W'(box_stk_pkg::HEIGHT_MAX)) ?
                       box_stk_pkg::HEIGHT_MAX : HT_W'(sorted_rd_ff[SIDE_BITS-1:0]);
            i_in     = '0;
            state_in = S_DP_I;
         end
         S_DP_I: begin
            state_in = (i_ff == j_ff) ? S_DP_PUT : S_DP_C;
         end
         S_DP_C: begin
            if ((sorted_rd_ff[ENT_W-1 -: SIDE_BITS] > cur_ff[ENT_W-1 -: SIDE_BITS]) &&
                (sorted_rd_ff[2*SIDE_BITS-1 -: SIDE_BITS] >
                 cur_ff[2*SIDE_BITS-1 -: SIDE_BITS]) &&
                (cand_sat > top_ff)) begin
               top_in = cand_sat;
            end
            i_in     = i_ff + CNT_W'(1);
            state_in = S_DP_I;
         end
         S_DP_PUT: begin
            if (top_ff > best_ff) begin
               best_in = top_ff;
            end
            j_in     = j_ff + CNT_W'(1);
            state_in = S_DP_J;
         end
         S_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_height_in = best_ff;
               count_in      = '0;
               best_in       = '0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         best_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         best_ff      <= best_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      phase_ff      <= phase_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      c_ff          <= c_in;
      last_ff       <= last_in;
      j_ff          <= j_in;
      i_ff          <= i_in;
      rank_ff       <= rank_in;
      cur_ff        <= cur_in;
      top_ff        <= top_in;
      rsp_height_ff <= rsp_height_in;
   end

   always_ff @(posedge clock) begin
      if (orient_we) begin
         orient_mem[count_ff[IDX_W-1:0]] <= orient_wdata;
      end
      orient_rd_ff <= orient_mem[orient_raddr];
   end

   always_ff @(posedge clock) begin
      if (sorted_we) begin
         sorted_mem[rank_ff[IDX_W-1:0]] <= cur_ff;
      end
      sorted_rd_ff <= sorted_mem[sorted_raddr];
   end

   always_ff @(posedge clock) begin
      if (height_we) begin
         height_mem[j_ff[IDX_W-1:0]] <= top_ff;
      end
      height_rd_ff <= height_mem[sorted_raddr];
   end

   // The store never holds more orientations than it has room for.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(ORIENTS))
      else $error("orientation count beyond store depth");

   // A ranked slot always lies inside the filled part of the store.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RK_PUT) |-> (rank_ff < count_ff))
      else $error("rank outside the loaded orientations");

   // The stacking pass only looks at boxes ranked ahead of the current one.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DP_C) |-> (i_ff < j_ff))
      else $error("stacking pass reads a later box");

   // The running best covers every chain height just stored.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DP_PUT) |=> (best_ff >= $past(top_ff)))
      else $error("running best below a stored chain height");

endmodule

/* bench/box_stacking_max_height_tb.sv */
module box_stacking_max_height_tb;

   localparam int MAX_TYPES = 64;
   localparam int SIDE_BITS = 16;
   localparam int HEIGHT_W  = box_stk_pkg::HEIGHT_W;
   localparam int N_ORIENT  = box_stk_pkg::ORIENTS_PER_BOX * MAX_TYPES;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [SIDE_BITS-1:0] req_side_a;
   logic [SIDE_BITS-1:0] req_side_b;
   logic [SIDE_BITS-1:0] req_side_c;
   logic                 req_no_box;
   logic                 req_last_box;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [HEIGHT_W-1:0]  rsp_best_height;

   box_stacking_max_height #(.MAX_TYPES(MAX_TYPES), .SIDE_BITS(SIDE_BITS)) uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_side_a(req_side_a), .req_side_b(req_side_b), .req_side_c(req_side_c),
      .req_no_box(req_no_box), .req_last_box(req_last_box),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_best_height(rsp_best_height)
   );

   // Shadow copy of the block's orientation store, in load order.
   typedef struct packed {
      logic [SIDE_BITS-1:0] w;
      logic [SIDE_BITS-1:0] d;
      logic [SIDE_BITS-1:0] h;
   } orient_type;

   orient_type          shadow_orients[N_ORIENT];
   int                  shadow_count;
   logic [HEIGHT_W-1:0] heights_due[$];
   int                  mismatches;
   int                  words_sent;
   int                  heights_seen;
   int                  sender_idle_pct;
   int                  receiver_stall_pct;

   // One row of the directed table. A typed-in height is checked against the
   // predictor too, so a wrong prediction shows up here first.
   typedef struct {
      logic [SIDE_BITS-1:0] a, b, c;
      logic                 no_box, last_box;
      logic                 has_known;
      logic [HEIGHT_W-1:0]  known;
   } row_type;

   row_type directed[$];

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #400000000;
      $display("timeout: %0d heights still due", heights_due.size());
      $display("** box_stacking_max_height: FAILED **");
      $finish;
   end

   task automatic report_mismatch(input string what);
      mismatches++;
      $display("mismatch at %0t: %s", $realtime, what);
   endtask

   task automatic add_row(input row_type r);
      directed.insert(directed.size(), r);
   endtask

   function automatic logic ranks_first(orient_type x, orient_type y);
      logic [2*SIDE_BITS-1:0] ax, ay;
      ax = x.w * x.d;
      ay = y.w * y.d;
      if (ax != ay) return ax > ay;
      if (x.w != y.w) return x.w > y.w;
      return x.d > y.d;
   endfunction

   function automatic orient_type make_orient(logic [SIDE_BITS-1:0] h,
                                              logic [SIDE_BITS-1:0] s,
                                              logic [SIDE_BITS-1:0] t);
      orient_type o;
      o.w = (s < t) ? s : t;
      o.d = (s < t) ? t : s;
      o.h = h;
      return o;
   endfunction

   // Rank the held orientations, then find the tallest strictly nested stack.
   function automatic logic [HEIGHT_W-1:0] tallest_stack();
      orient_type    ranked[N_ORIENT];
      longint        tops[N_ORIENT];
      orient_type    key;
      longint        best, top;
      int            j;
      best = 0;
      for (int i = 0; i < shadow_count; i++) ranked[i] = shadow_orients[i];
      for (int i = 1; i < shadow_count; i++) begin
         key = ranked[i];
         j = i;
         while (j > 0 && ranks_first(key, ranked[j-1])) begin
            ranked[j] = ranked[j-1];
            j--;
         end
         ranked[j] = key;
      end
      for (int k = 0; k < shadow_count; k++) begin
         top = ranked[k].h;
         for (int i = 0; i < k; i++)
            if (ranked[i].w > ranked[k].w && ranked[i].d > ranked[k].d)
               if (tops[i] + ranked[k].h > top) top = tops[i] + ranked[k].h;
         tops[k] = top;
         if (top > best) best = top;
      end
      return (best > box_stk_pkg::HEIGHT_MAX) ? box_stk_pkg::HEIGHT_MAX
                                              : best[HEIGHT_W-1:0];
   endfunction

   // Apply one accepted word to the shadow state; queue a height on a close.
   task automatic absorb_word(input row_type r);
      if (!r.no_box && shadow_count + box_stk_pkg::ORIENTS_PER_BOX <= N_ORIENT) begin
         shadow_orients[shadow_count]   = make_orient(r.a, r.b, r.c);
         shadow_orients[shadow_count+1] = make_orient(r.b, r.c, r.a);
         shadow_orients[shadow_count+2] = make_orient(r.c, r.a, r.b);
         shadow_count += box_stk_pkg::ORIENTS_PER_BOX;
      end
      if (r.last_box) begin
         logic [HEIGHT_W-1:0] h;
         h = tallest_stack();
         if (r.has_known && h != r.known)
            report_mismatch($sformatf("table row expects %0d, predictor says %0d",
                                      r.known, h));
         heights_due.insert(heights_due.size(), h);
         shadow_count = 0;
      end
   endtask

   // Present one word and hold it until the block takes it. The valid line is
   // only lowered when an idle gap follows, so back-to-back words keep it high.
   task automatic send_word(input row_type r);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_side_a   <= r.a;
      req_side_b   <= r.b;
      req_side_c   <= r.c;
      req_no_box   <= r.no_box;
      req_last_box <= r.last_box;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      absorb_word(r);
      words_sent++;
   endtask

   function automatic row_type box_row(int a, int b, int c, bit last_flag);
      row_type r;
      r.a = SIDE_BITS'(a); r.b = SIDE_BITS'(b); r.c = SIDE_BITS'(c);
      r.no_box = 1'b0; r.last_box = last_flag;
      r.has_known = 1'b0; r.known = '0;
      return r;
   endfunction

   function automatic row_type random_box(bit last_flag, int top);
      return box_row($urandom_range(top), $urandom_range(top), $urandom_range(top),
                     last_flag);
   endfunction

   // The receiver stalls at random; results are sampled at the edge where
   // valid is high and stall is low.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            heights_seen++;
            if (heights_due.size() == 0) begin
               report_mismatch($sformatf("unexpected height %0d", rsp_best_height));
            end else begin
               if (rsp_best_height !== heights_due[0])
                  report_mismatch($sformatf("best_height %0d, expected %0d",
                                            rsp_best_height, heights_due[0]));
               void'(heights_due.pop_front());
            end
         end
         rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
      end
   end

   initial begin
      row_type r;
      int      set_len;
      mismatches = 0; words_sent = 0; heights_seen = 0; shadow_count = 0;
      sender_idle_pct = 0; receiver_stall_pct = 0;
      reset <= 1'b1;
      req_valid <= 1'b0; req_side_a <= '0; req_side_b <= '0; req_side_c <= '0;
      req_no_box <= 1'b0; req_last_box <= 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed rows: empty set right after reset, a lone box that stacks on
      // itself turned over, the largest sides, zero sides, equal bases that
      // cannot nest, and a proper nest of four boxes.
      r = box_row(0, 0, 0, 1'b1); r.no_box = 1'b1;
      r.has_known = 1'b1; r.known = 0;
      add_row(r);
      r = box_row(1, 2, 3, 1'b1); r.has_known = 1'b1; r.known = 4;
      add_row(r);
      r = box_row(65535, 65535, 65535, 1'b1); r.has_known = 1'b1; r.known = 65535;
      add_row(r);
      r = box_row(0, 0, 0, 1'b1); r.has_known = 1'b1; r.known = 0;
      add_row(r);
      add_row(box_row(5, 5, 5, 1'b0));
      r = box_row(5, 5, 5, 1'b1); r.has_known = 1'b1; r.known = 5;
      add_row(r);
      add_row(box_row(4, 6, 7, 1'b0));
      add_row(box_row(1, 2, 3, 1'b0));
      add_row(box_row(4, 5, 6, 1'b0));
      r = box_row(10, 12, 32, 1'b0); add_row(r);
      r = box_row(0, 0, 0, 1'b1); r.no_box = 1'b1; add_row(r);
      // A box word that also closes, with a no-box word inside the set.
      r = box_row(0, 0, 0, 1'b0); r.no_box = 1'b1; add_row(r);
      add_row(box_row(65535, 1, 32768, 1'b0));
      add_row(box_row(21845, 43690, 65534, 1'b1));
      // Sides ignored on a no-box word, even all ones.
      r = box_row(65535, 65535, 65535, 1'b1); r.no_box = 1'b1;
      r.has_known = 1'b1; r.known = 0;
      add_row(r);
      foreach (directed[i]) send_word(directed[i]);

      // A full store: the last box past MAX_TYPES types must be dropped.
      for (int i = 0; i <= MAX_TYPES; i++)
         send_word(random_box(i == MAX_TYPES, 65535));

      // Random sets in four pressure phases. Most sets are small so the
      // quadratic ranking pass stays cheap; some boxes use narrow sides to force
      // ties and nesting, and a few sets hold more words than the store has box slots.
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 68; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 68; end
            default: begin sender_idle_pct = 10; receiver_stall_pct = 10; end
         endcase
         while (words_sent < 100 + (ph + 1) * 200) begin
            set_len = ($urandom_range(19) == 0) ? MAX_TYPES + 2 : $urandom_range(1, 6);
            for (int k = 0; k < set_len; k++) begin
               r = random_box(k == set_len - 1,
                              ($urandom_range(1) != 0) ? 15 : 65535);
               if ($urandom_range(9) == 0) r.no_box = 1'b1;
               send_word(r);
            end
         end
      end
      req_valid <= 1'b0;

      // Wait for the last result, then a few quiet cycles for strays.
      while (heights_due.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);

      $display("%0d words sent, %0d stack heights checked, idle/stall phases 0-68%%",
               words_sent, heights_seen);
      if (mismatches == 0) begin
         $display("** box_stacking_max_height: PASSED **");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("** box_stacking_max_height: FAILED **");
      end
      $finish;
   end

endmodule

/* sim.f */
src/box_stk_pkg.sv
src/box_stacking_max_height.sv
bench/box_stacking_max_height_tb.sv
